@@ rtl/core/u2u8_pkg.sv @@
// Shared types, constants and the UTF-8 byte builder for the UTF-16 to UTF-8 transcoder.
package u2u8_pkg;

	// Input transaction: one UTF-16 code unit.
	typedef struct packed {
		logic [15:0] code_unit;
		logic        end_of_string;
	} unit_t;

	// Output transaction: one UTF-8 byte or one status item.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       stream_end;
		logic       error;
	} res_t;

	// Work for the back end: up to four bytes, or one status item.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            status;
		logic            stream_end;
		logic            error;
	} job_t;

	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	localparam logic [5:0]  HighTag  = 6'b110110;    // 0xD800..0xDBFF
	localparam logic [5:0]  LowTag   = 6'b110111;    // 0xDC00..0xDFFF
	localparam logic [20:0] SuppBase = 21'h10000;

	function automatic job_t status_job(logic eos, logic err);
		job_t j;
		j            = '0;
		j.status     = 1'b1;
		j.stream_end = eos;
		j.error      = err;
		return j;
	endfunction

	// UTF-8 bytes of a nonzero code point, first byte in bytes[0].
	function automatic job_t data_job(logic [20:0] cp, logic eos);
		job_t j;
		j            = '0;
		j.stream_end = eos;
		if (cp[20:7] == '0) begin
			j.bytes[0] = cp[7:0];
			j.last_idx = 2'd0;
		end else if (cp[20:11] == '0) begin
			j.bytes[0] = {3'b110, cp[10:6]};
			j.bytes[1] = {2'b10, cp[5:0]};
			j.last_idx = 2'd1;
		end else if (cp[20:16] == '0) begin
			j.bytes[0] = {4'b1110, cp[15:12]};
			j.bytes[1] = {2'b10, cp[11:6]};
			j.bytes[2] = {2'b10, cp[5:0]};
			j.last_idx = 2'd2;
		end else begin
			j.bytes[0] = {5'b11110, cp[20:18]};
			j.bytes[1] = {2'b10, cp[17:12]};
			j.bytes[2] = {2'b10, cp[11:6]};
			j.bytes[3] = {2'b10, cp[5:0]};
			j.last_idx = 2'd3;
		end
		return j;
	endfunction

endpackage

@@ rtl/core/u2u8_front.sv @@
// Front end: accepts code units, tracks surrogate and error state, builds byte jobs.
module u2u8_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             unit_valid,
	output logic             unit_stall,
	input  u2u8_pkg::unit_t  unit_data,
	input  logic             q_full,
	output logic             push,
	output u2u8_pkg::job_t   push_job
);
	import u2u8_pkg::*;

	logic [9:0]  pend_hi_q;
	logic        pend_q;
	logic        err_q;
	logic        take;
	logic        is_high;
	logic        is_low;
	logic [20:0] pair_cp;
	logic [20:0] cp;
	logic        do_data;
	logic        do_fail;
	logic        hold_high;
	logic        eos;

	assign unit_stall = q_full;
	assign take       = unit_valid && !q_full;
	assign eos        = unit_data.end_of_string;
	assign is_high    = unit_data.code_unit[15:10] == HighTag;
	assign is_low     = unit_data.code_unit[15:10] == LowTag;
	assign pair_cp    = {1'b0, pend_hi_q, unit_data.code_unit[9:0]} + SuppBase;

	always_comb begin
		do_data   = 1'b0;
		do_fail   = 1'b0;
		hold_high = 1'b0;
		cp        = {5'd0, unit_data.code_unit};
		if (!err_q) begin
			if (pend_q) begin
				if (is_low) begin
					do_data = 1'b1;
					cp      = pair_cp;
				end else begin
					do_fail = 1'b1;
				end
			end else if (is_high) begin
				if (eos) do_fail = 1'b1;
				else hold_high = 1'b1;
			end else if (is_low) begin
				do_fail = 1'b1;
			end else begin
				do_data = 1'b1;
			end
		end
	end

	always_comb begin
		push     = 1'b0;
		push_job = status_job(eos, 1'b0);
		if (take) begin
			if (err_q) begin
				push     = eos;
				push_job = status_job(1'b1, 1'b1);
			end else if (do_fail) begin
				push     = 1'b1;
				push_job = status_job(eos, 1'b1);
			end else if (do_data) begin
				if (cp == '0) begin
					push     = eos;        // zero unit: only the end marker
					push_job = status_job(1'b1, 1'b0);
				end else begin
					push     = 1'b1;
					push_job = data_job(cp, eos);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			err_q  <= 1'b0;
		end else if (take) begin
			pend_q <= hold_high;
			err_q  <= eos ? 1'b0 : (err_q || do_fail);
		end
	end

	always_ff @(posedge clk) begin
		if (take && hold_high) pend_hi_q <= unit_data.code_unit[9:0];
	end

endmodule

@@ rtl/core/u2u8_queue.sv @@
// Small FIFO of byte jobs between the front and back ends.
module u2u8_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  u2u8_pkg::job_t  push_job,
	input  logic            pop,
	output logic            full,
	output logic            nonempty,
	output u2u8_pkg::job_t  head
);
	import u2u8_pkg::*;

	job_t             mem_q [QDepth];
	logic [QPtrW-1:0] wr_q;
	logic [QPtrW-1:0] rd_q;
	logic [QCntW-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = cnt_q == QCntW'(QDepth);
	assign nonempty = cnt_q != '0;
	assign head     = mem_q[rd_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_job;
	end

endmodule

@@ rtl/core/u2u8_back.sv @@
// Back end: serializes each job into result transactions through an output register.
module u2u8_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            nonempty,
	input  u2u8_pkg::job_t  head,
	output logic            pop,
	output logic            res_valid,
	input  logic            res_stall,
	output u2u8_pkg::res_t  res_data
);
	import u2u8_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	res_t       res_q;
	logic       load;
	logic       last;
	res_t       nxt;

	assign load = nonempty && (!valid_q || !res_stall);
	assign last = idx_q == head.last_idx;
	assign pop  = load && last;

	always_comb begin
		nxt.out_byte   = head.status ? 8'd0 : head.bytes[idx_q];
		nxt.byte_valid = !head.status;
		nxt.run_last   = last;
		nxt.stream_end = last && head.stream_end;
		nxt.error      = head.error;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last ? 2'd0 : idx_q + 2'd1;
			end else if (!res_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= nxt;
	end

	assign res_valid = valid_q;
	assign res_data  = res_q;

endmodule

@@ rtl/core/utf16_to_utf8_transcoder_top.sv @@
// UTF-16 to UTF-8 transcoder: top level joining front end, job queue and back end.
// A unit's job is queued; its results leave through the back end's output register.
// Throughput: one result transaction per cycle while res_stall is low, set by the back
// end's byte serializer; a code unit yields up to four results (its UTF-8 length).
// The front accepts one unit per cycle while the 4-entry job queue has room.
// Reset (arst_n low, asynchronous) clears surrogate, error, queue and output state.
module utf16_to_utf8_transcoder_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             unit_valid,
	output logic             unit_stall,
	input  u2u8_pkg::unit_t  unit_data,
	output logic             res_valid,
	input  logic             res_stall,
	output u2u8_pkg::res_t   res_data
);
	import u2u8_pkg::*;

	logic q_full;
	logic q_nonempty;
	logic push;
	logic pop;
	job_t push_job;
	job_t head;

	// Classification: surrogate pairing, error latch, byte building.
	u2u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.unit_valid (unit_valid),
		.unit_stall (unit_stall),
		.unit_data  (unit_data),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	// Decouples the unit side from the byte side.
	u2u8_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.head     (head)
	);

	// One byte (or status item) per transaction.
	u2u8_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.nonempty  (q_nonempty),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

@@ dv/utf16_to_utf8_transcoder_top_tb.sv @@
// Self-checking testbench for the UTF-16 to UTF-8 transcoder top level.
`timescale 1ns / 100ps

module utf16_to_utf8_transcoder_top_tb;
	import u2u8_pkg::*;

	// Clock, reset and run length
	localparam int HalfPeriod  = 10;          // 20 ns clock
	localparam int ResetCycles = 6;
	localparam int TimeLimitNs = 5_000_000;   // several times the slowest legal run
	localparam int DrainCycles = 10;          // leave slack for stray results

	// Stimulus sizing
	localparam int NumDirected = 28;
	localparam int RandomUnits = 382;         // random units sent after the directed table
	localparam int HoldAt      = NumDirected + 60;
	localparam int LongHold    = 60;          // cycles the receiver blocks once

	// UTF-16 code unit ranges
	localparam logic [15:0] HighFirst = 16'hD800;
	localparam logic [15:0] HighLast  = 16'hDBFF;
	localparam logic [15:0] LowFirst  = 16'hDC00;
	localparam logic [15:0] LowLast   = 16'hDFFF;
	localparam logic [20:0] PlaneOne  = 21'h10000;

	// One directed row: a code unit, and optionally the results written out by hand.
	typedef struct packed {
		unit_t      unit;
		logic       typed;    // 1: use want[] below; 0: use the encoder model
		logic [2:0] count;    // number of results in want[]
		res_t [0:3] want;
	} dir_row_t;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  unit_valid;
	logic  unit_stall;
	unit_t unit_data;
	logic  res_valid;
	logic  res_stall;
	res_t  res_data;

	// Encoder model state
	logic [9:0] held_high;     // low 10 bits of a pending high surrogate
	logic       high_held;
	logic       discarding;    // malformed string, dropping units until its end

	res_t     step_items[$];       // results caused by the unit just accepted
	res_t     utf8_expected[$];    // results still owed by the DUT
	res_t     head_item;
	dir_row_t dir_rows[NumDirected];

	int fail_count  = 0;
	int units_in    = 0;           // every accepted unit
	bit hold_active = 1'b0;        // receiver is in its long hold-off
	bit hold_done   = 1'b0;

	utf16_to_utf8_transcoder_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.unit_valid (unit_valid),
		.unit_stall (unit_stall),
		.unit_data  (unit_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data)
	);

	always #HalfPeriod clk = ~clk;

	// ------------------------------------------------------------------
	// Result builders
	// ------------------------------------------------------------------
	function automatic res_t byte_item(logic [7:0] b, logic last, logic fin);
		res_t r;
		r.out_byte   = b;
		r.byte_valid = 1'b1;
		r.run_last   = last;
		r.stream_end = fin;
		r.error      = 1'b0;
		return r;
	endfunction

	// Status-only transaction: no byte, always the last result of its unit.
	function automatic res_t status_item(logic fin, logic err);
		res_t r;
		r.out_byte   = 8'h00;
		r.byte_valid = 1'b0;
		r.run_last   = 1'b1;
		r.stream_end = fin;
		r.error      = err;
		return r;
	endfunction

	function automatic dir_row_t row(logic [15:0] cu, logic eos, logic typed = 1'b0,
			int count = 0, res_t w0 = '0, res_t w1 = '0, res_t w2 = '0, res_t w3 = '0);
		dir_row_t d;
		d.unit.code_unit     = cu;
		d.unit.end_of_string = eos;
		d.typed              = typed;
		d.count              = 3'(count);
		d.want               = {w0, w1, w2, w3};
		return d;
	endfunction

	// ------------------------------------------------------------------
	// Encoder model
	// ------------------------------------------------------------------

	// Malformed input: one error transaction. Mid-string, the rest of the string
	// is dropped; on the end unit the string simply closes.
	function automatic void flag_malformed(logic eos);
		step_items = {step_items, status_item(eos, 1'b1)};
		high_held  = 1'b0;
		held_high  = '0;
		discarding = !eos;
	endfunction

	function automatic void transcode_unit(unit_t u);
		logic [15:0] cu;
		logic        eos;
		logic        is_high;
		logic        is_low;
		logic [20:0] cp;
		logic [7:0]  b[4];
		int          n;

		cu      = u.code_unit;
		eos     = u.end_of_string;
		is_high = (cu >= HighFirst) && (cu <= HighLast);
		is_low  = (cu >= LowFirst) && (cu <= LowLast);
		step_items.delete();

		if (discarding) begin
			// only the end unit of a bad string speaks
			if (eos) begin
				step_items = {step_items, status_item(1'b1, 1'b1)};
				discarding = 1'b0;
			end
			return;
		end

		if (high_held) begin
			if (!is_low) begin
				flag_malformed(eos);
				return;
			end
			cp        = {1'b0, held_high, cu[9:0]} + PlaneOne;
			high_held = 1'b0;
			held_high = '0;
		end else if (is_high) begin
			if (eos) begin
				flag_malformed(eos);
				return;
			end
			held_high = cu[9:0];
			high_held = 1'b1;
			return;
		end else if (is_low) begin
			flag_malformed(eos);
			return;
		end else begin
			cp = {5'b0, cu};
		end

		// NUL: no bytes, but the end of string still gets its closing status
		if (cp == '0) begin
			if (eos)
				step_items = {step_items, status_item(1'b1, 1'b0)};
			return;
		end

		if (cp < 21'h80) begin
			n    = 1;
			b[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			n    = 2;
			b[0] = 8'hC0 | 8'(cp >> 6);
			b[1] = 8'h80 | 8'(cp & 21'h3F);
		end else if (cp < PlaneOne) begin
			n    = 3;
			b[0] = 8'hE0 | 8'(cp >> 12);
			b[1] = 8'h80 | 8'((cp >> 6) & 21'h3F);
			b[2] = 8'h80 | 8'(cp & 21'h3F);
		end else begin
			n    = 4;
			b[0] = 8'hF0 | 8'((cp >> 18) & 21'h07);
			b[1] = 8'h80 | 8'((cp >> 12) & 21'h3F);
			b[2] = 8'h80 | 8'((cp >> 6) & 21'h3F);
			b[3] = 8'h80 | 8'(cp & 21'h3F);
		end
		for (int i = 0; i < n; i++)
			step_items = {step_items, byte_item(b[i], i == n - 1, (i == n - 1) && eos)};
	endfunction

	// ------------------------------------------------------------------
	// Idle / stall lengths: mostly short, now and then long
	// ------------------------------------------------------------------
	function automatic int gap_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	// ------------------------------------------------------------------
	// Sender: drives one code unit and returns at its acceptance edge.
	// quiet strings and the long receiver hold-off get no idle gaps, so the
	// job queue fills and unit_stall has to rise.
	// ------------------------------------------------------------------
	task automatic send_unit(unit_t u, bit quiet);
		int gap;

		@(negedge clk);
		gap = (quiet || hold_active || $urandom_range(0, 99) < 50) ? 0 : gap_len();
		if (gap > 0) begin
			unit_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		unit_valid <= 1'b1;
		unit_data  <= u;
		do
			@(posedge clk);
		while (unit_stall);
		units_in++;
	endtask

	// Random string of 1 to 8 elements. Mostly well-formed text, including
	// surrogate pairs; the rest is NULs, lone surrogates and raw noise.
	task automatic send_string();
		unit_t       s[$];
		unit_t       u;
		int          len;
		int          pick;
		bit          quiet;
		logic [15:0] cu;

		len   = $urandom_range(1, 8);
		quiet = ($urandom_range(0, 5) == 0);
		for (int k = 0; k < len; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 28)
				cu = 16'($urandom_range(1, 16'h7F));
			else if (pick < 43)
				cu = 16'($urandom_range(16'h80, 16'h7FF));
			else if (pick < 58)
				cu = $urandom_range(0, 1) ? 16'($urandom_range(16'h800, 16'hD7FF))
				                          : 16'($urandom_range(16'hE000, 16'hFFFF));
			else if (pick < 80) begin
				u.code_unit     = 16'($urandom_range(HighFirst, HighLast));
				u.end_of_string = 1'b0;
				s = {s, u};
				cu = 16'($urandom_range(LowFirst, LowLast));
			end else if (pick < 84)
				cu = 16'h0000;
			else if (pick < 88)
				cu = 16'($urandom_range(LowFirst, LowLast));
			else if (pick < 92)
				cu = 16'($urandom_range(HighFirst, HighLast));
			else
				cu = 16'($urandom());
			u.code_unit     = cu;
			u.end_of_string = 1'b0;
			s = {s, u};
		end
		s[s.size() - 1].end_of_string = 1'b1;

		foreach (s[k]) begin
			send_unit(s[k], quiet);
			transcode_unit(s[k]);
			foreach (step_items[j])
				utf8_expected = {utf8_expected, step_items[j]};
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence: reset, directed table, random strings, drain
	// ------------------------------------------------------------------
	initial begin : stimulus
		arst_n     = 1'b0;
		unit_valid = 1'b0;
		unit_data  = '0;
		high_held  = 1'b0;
		held_high  = '0;
		discarding = 1'b0;

		dir_rows = '{
			// ASCII, including its highest code 0x7F
			row(16'h0041, 1'b0, 1'b1, 1, byte_item(8'h41, 1'b1, 1'b0)),
			row(16'h007F, 1'b0, 1'b1, 1, byte_item(8'h7F, 1'b1, 1'b0)),
			// length boundaries around two and three bytes, and around the surrogates
			row(16'h0080, 1'b0),
			row(16'h07FF, 1'b0),
			row(16'h0800, 1'b0),
			row(16'hD7FF, 1'b0),
			row(16'hE000, 1'b0),
			row(16'hFFFF, 1'b1, 1'b1, 3, byte_item(8'hEF, 1'b0, 1'b0),
				byte_item(8'hBF, 1'b0, 1'b0), byte_item(8'hBF, 1'b1, 1'b1)),
			// NUL mid-string is silent; NUL at the end only closes the string
			row(16'h0000, 1'b0, 1'b1, 0),
			row(16'h0000, 1'b1, 1'b1, 1, status_item(1'b1, 1'b0)),
			row(16'h0001, 1'b1, 1'b1, 1, byte_item(8'h01, 1'b1, 1'b1)),
			// lowest and highest supplementary code points
			row(16'hD800, 1'b0, 1'b1, 0),
			row(16'hDC00, 1'b0, 1'b1, 4, byte_item(8'hF0, 1'b0, 1'b0),
				byte_item(8'h90, 1'b0, 1'b0), byte_item(8'h80, 1'b0, 1'b0),
				byte_item(8'h80, 1'b1, 1'b0)),
			row(16'hDBFF, 1'b0, 1'b1, 0),
			row(16'hDFFF, 1'b1, 1'b1, 4, byte_item(8'hF4, 1'b0, 1'b0),
				byte_item(8'h8F, 1'b0, 1'b0), byte_item(8'hBF, 1'b0, 1'b0),
				byte_item(8'hBF, 1'b1, 1'b1)),
			// lone low surrogate, on the end unit and mid-string
			row(16'hDC00, 1'b1, 1'b1, 1, status_item(1'b1, 1'b1)),
			row(16'hDFFF, 1'b0, 1'b1, 1, status_item(1'b0, 1'b1)),
			// rest of a bad string is dropped until its end unit
			row(16'h0041, 1'b0, 1'b1, 0),
			row(16'h0000, 1'b1, 1'b1, 1, status_item(1'b1, 1'b1)),
			// high surrogate followed by a plain unit
			row(16'hD800, 1'b0, 1'b1, 0),
			row(16'h0041, 1'b0, 1'b1, 1, status_item(1'b0, 1'b1)),
			row(16'h1234, 1'b1, 1'b1, 1, status_item(1'b1, 1'b1)),
			// high surrogate followed by NUL
			row(16'hDAAA, 1'b0, 1'b1, 0),
			row(16'h0000, 1'b0, 1'b1, 1, status_item(1'b0, 1'b1)),
			row(16'hD955, 1'b1, 1'b1, 1, status_item(1'b1, 1'b1)),
			// high surrogate on the end unit
			row(16'hDB00, 1'b1, 1'b1, 1, status_item(1'b1, 1'b1)),
			// a mid-range pair
			row(16'hD955, 1'b0),
			row(16'hDEAA, 1'b1)
		};

		repeat (ResetCycles) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			send_unit(dir_rows[i].unit, 1'b0);
			transcode_unit(dir_rows[i].unit);
			if (dir_rows[i].typed) begin
				step_items.delete();
				for (int k = 0; k < dir_rows[i].count; k++)
					step_items = {step_items, dir_rows[i].want[k]};
			end
			foreach (step_items[k])
				utf8_expected = {utf8_expected, step_items[k]};
		end

		while (units_in < NumDirected + RandomUnits)
			send_string();

		@(negedge clk);
		unit_valid <= 1'b0;

		// wait for every owed result, then DrainCycles more for stray ones
		while (utf8_expected.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: random stall runs, plus one long hold-off while the sender
	// keeps pushing so the whole pipe backs up.
	// ------------------------------------------------------------------
	initial begin : receiver
		int stall_left;
		bit stalling;

		stall_left = 0;
		stalling   = 1'b0;
		res_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0) begin
				hold_active = 1'b0;
				if (!hold_done && units_in >= HoldAt) begin
					hold_done   = 1'b1;
					hold_active = 1'b1;
					stalling    = 1'b1;
					stall_left  = LongHold;
				end else begin
					stalling   = ($urandom_range(0, 99) < 35);
					// free runs are usually short, sometimes long stretches
					stall_left = stalling ? gap_len()
					           : $urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 8);
				end
			end
			res_stall <= stalling;
			stall_left--;
		end
	end

	// ------------------------------------------------------------------
	// Result checker: every accepted transaction against the oldest expectation
	// ------------------------------------------------------------------
	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (utf8_expected.size() == 0) begin
				$error("unexpected result transaction: %p", res_data);
				fail_count++;
			end else begin
				head_item = utf8_expected.pop_front();
				check_field("out_byte", head_item.out_byte, res_data.out_byte);
				check_field("byte_valid", 8'(head_item.byte_valid), 8'(res_data.byte_valid));
				check_field("run_last", 8'(head_item.run_last), 8'(res_data.run_last));
				check_field("stream_end", 8'(head_item.stream_end), 8'(res_data.stream_end));
				check_field("error", 8'(head_item.error), 8'(res_data.error));
			end
		end
	end

	// Watchdog
	initial begin : watchdog
		#(TimeLimitNs);
		$display("== FAIL ==");
		$finish;
	end

endmodule
